// ===== hw/rtl/lcdbs_pkg.sv =====
// Shared types, sizes and constants for the double-buffered LED cube scanner.
// Used by lcdbs_ctrl, lcdbs_dp and led_cube_double_buffered_scanner; no dependencies.
package lcdbs_pkg;

	localparam int LEVELS        = 5;
	localparam int WORD_BITS     = 32;
	localparam int MESSAGE_BYTES = 21;

	localparam int WORD_BYTES  = (WORD_BITS + 7) / 8;
	localparam int LEVEL_W     = 3;
	localparam int BIT_CNT_W   = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
	localparam int STAGE_IDX_W = $clog2(MESSAGE_BYTES);
	localparam int STAGE_CNT_W = $clog2(MESSAGE_BYTES + 1);
	localparam int FRAME_DEPTH = 2 * LEVELS;
	localparam int FRAME_IDX_W = $clog2(FRAME_DEPTH);
	localparam int LOAD_BYTES  = 1 + LEVELS * WORD_BYTES;
	localparam int PAD_BYTES   = (LOAD_BYTES > MESSAGE_BYTES) ? LOAD_BYTES : MESSAGE_BYTES;

	localparam logic [7:0] LOAD_FRAME_OP = 8'h00;

	localparam logic [63:0] PATTERN [5] = '{
		64'hF000_0001, 64'hE800_0002, 64'hD800_0004, 64'hB800_0008, 64'h7800_0010
	};

	typedef enum logic [1:0] {
		CMD_TICK = 2'd0,
		CMD_BYTE = 2'd1,
		CMD_WEND = 2'd2,
		CMD_REND = 2'd3
	} cmd_t;

	typedef enum logic {
		ST_IDLE  = 1'b0,
		ST_SHIFT = 1'b1
	} state_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic tick_load;
		logic shift;
		logic tick_done;
		logic byte_wr;
		logic write_end;
		logic read_end;
	} ctl_cmd_t;

	// Power-up test pattern for one level
	function automatic logic [WORD_BITS-1:0] pattern_word(input int lvl);
		logic [63:0] v;
		v = 64'd0;
		if (lvl < 5) begin
			v = PATTERN[lvl];
		end
		return v[WORD_BITS-1:0];
	endfunction

endpackage

// ===== hw/rtl/lcdbs_ctrl.sv =====
// Controller of the LED cube scanner: request decode, shift sequencing, bit counter.
// Depends on lcdbs_pkg.
module lcdbs_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [1:0]            command,
	output logic                  busy,
	output logic                  strobe,
	output logic                  latch_after,
	output lcdbs_pkg::ctl_cmd_t   cmd
);

	lcdbs_pkg::state_t                  state_q, state_d;
	logic [lcdbs_pkg::BIT_CNT_W-1:0]    cnt_q;
	logic                               last_bit;
	logic                               accept;
	lcdbs_pkg::cmd_t                    op;

	assign op       = lcdbs_pkg::cmd_t'(command);
	assign accept   = start && (state_q == lcdbs_pkg::ST_IDLE);
	assign last_bit = (cnt_q == lcdbs_pkg::BIT_CNT_W'(lcdbs_pkg::WORD_BITS - 1));

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lcdbs_pkg::ST_IDLE: begin
				if (accept && op == lcdbs_pkg::CMD_TICK) begin
					state_d = lcdbs_pkg::ST_SHIFT;
				end
			end
			lcdbs_pkg::ST_SHIFT: begin
				if (last_bit) begin
					state_d = lcdbs_pkg::ST_IDLE;
				end
			end
			default: state_d = lcdbs_pkg::ST_IDLE;
		endcase
	end

	// Outputs and datapath commands
	always_comb begin
		busy          = 1'b0;
		strobe        = 1'b0;
		latch_after   = 1'b0;
		cmd           = '0;
		unique case (state_q)
			lcdbs_pkg::ST_IDLE: begin
				if (accept) begin
					unique case (op)
						lcdbs_pkg::CMD_TICK: cmd.tick_load = 1'b1;
						lcdbs_pkg::CMD_BYTE: cmd.byte_wr   = 1'b1;
						lcdbs_pkg::CMD_WEND: cmd.write_end = 1'b1;
						lcdbs_pkg::CMD_REND: cmd.read_end  = 1'b1;
						default: cmd = '0;
					endcase
				end
			end
			lcdbs_pkg::ST_SHIFT: begin
				busy          = 1'b1;
				strobe        = 1'b1;
				latch_after   = last_bit;
				cmd.shift     = 1'b1;
				cmd.tick_done = last_bit;
			end
			default: cmd = '0;
		endcase
	end

	// Hold state; advance the bit counter while shifting
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lcdbs_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == lcdbs_pkg::ST_SHIFT && !last_bit) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
		end
	end

endmodule

// ===== hw/rtl/lcdbs_dp.sv =====
// Datapath of the LED cube scanner: frame store halves, staging bytes, shift register, LEDs.
// Depends on lcdbs_pkg; driven by lcdbs_ctrl commands.
module lcdbs_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  lcdbs_pkg::ctl_cmd_t             cmd,
	input  logic [7:0]                      data_byte,
	input  logic                            transfer_ok,
	output logic                            serial_bit,
	output logic [lcdbs_pkg::LEVEL_W-1:0]   level_index,
	output logic                            write_led,
	output logic                            read_led
);

	logic [lcdbs_pkg::WORD_BITS-1:0]     frame_q [lcdbs_pkg::FRAME_DEPTH];
	logic [7:0]                          stage_q [lcdbs_pkg::MESSAGE_BYTES];
	logic [lcdbs_pkg::STAGE_CNT_W-1:0]   count_q;
	logic [lcdbs_pkg::LEVEL_W-1:0]       level_q;
	logic                                front_q;
	logic                                swap_pending_q;
	logic                                write_led_q;
	logic                                read_led_q;
	logic [lcdbs_pkg::WORD_BITS-1:0]     shift_q;

	logic                                do_swap;
	logic                                front_next;
	logic [lcdbs_pkg::FRAME_IDX_W-1:0]   rd_idx;
	logic [lcdbs_pkg::PAD_BYTES-1:0][7:0] padded;
	logic [lcdbs_pkg::WORD_BITS-1:0]     load_word [lcdbs_pkg::LEVELS];
	logic [lcdbs_pkg::WORD_BYTES*8-1:0]  wide_word [lcdbs_pkg::LEVELS];
	logic                                load_back;

	// Swap halves on a tick at level zero with a pending swap
	assign do_swap    = (level_q == '0) && swap_pending_q;
	assign front_next = front_q ^ do_swap;
	assign rd_idx     = front_next
		? lcdbs_pkg::FRAME_IDX_W'(lcdbs_pkg::LEVELS + int'(level_q))
		: lcdbs_pkg::FRAME_IDX_W'(level_q);

	// Staged bytes past the fill count read as zero
	always_comb begin
		padded = '0;
		for (int i = 0; i < lcdbs_pkg::MESSAGE_BYTES; i++) begin
			if (lcdbs_pkg::STAGE_CNT_W'(i) < count_q) begin
				padded[i] = stage_q[i];
			end
		end
	end

	// Assemble the payload words little-endian
	always_comb begin
		for (int w = 0; w < lcdbs_pkg::LEVELS; w++) begin
			for (int b = 0; b < lcdbs_pkg::WORD_BYTES; b++) begin
				wide_word[w][8*b +: 8] = padded[1 + w*lcdbs_pkg::WORD_BYTES + b];
			end
			load_word[w] = wide_word[w][lcdbs_pkg::WORD_BITS-1:0];
		end
	end

	assign load_back = cmd.write_end && transfer_ok && (padded[0] == lcdbs_pkg::LOAD_FRAME_OP);

	// Frame store: test pattern at reset, back half loaded on a frame-load request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int h = 0; h < 2; h++) begin
				for (int l = 0; l < lcdbs_pkg::LEVELS; l++) begin
					frame_q[h*lcdbs_pkg::LEVELS + l] <= lcdbs_pkg::pattern_word(l);
				end
			end
		end else if (load_back) begin
			for (int w = 0; w < lcdbs_pkg::LEVELS; w++) begin
				if (front_q) begin
					frame_q[w] <= load_word[w];
				end else begin
					frame_q[lcdbs_pkg::LEVELS + w] <= load_word[w];
				end
			end
		end
	end

	// Staging bytes, opcode first and then payload; the fill count marks what is valid
	always_ff @(posedge clk) begin
		if (cmd.byte_wr && count_q < lcdbs_pkg::STAGE_CNT_W'(lcdbs_pkg::MESSAGE_BYTES)) begin
			stage_q[count_q[lcdbs_pkg::STAGE_IDX_W-1:0]] <= data_byte;
		end
	end

	// Shift register: load the level word, then drop one bit per cycle
	always_ff @(posedge clk) begin
		if (cmd.tick_load) begin
			shift_q <= frame_q[rd_idx];
		end else if (cmd.shift) begin
			shift_q <= shift_q >> 1;
		end
	end

	// Control state: fill count, level, halves, swap flag, LEDs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q        <= '0;
			level_q        <= '0;
			front_q        <= 1'b0;
			swap_pending_q <= 1'b0;
			write_led_q    <= 1'b0;
			read_led_q     <= 1'b0;
		end else begin
			if (cmd.byte_wr && count_q < lcdbs_pkg::STAGE_CNT_W'(lcdbs_pkg::MESSAGE_BYTES)) begin
				count_q <= count_q + 1'b1;
			end
			if (cmd.write_end || cmd.read_end) begin
				count_q <= '0;
			end
			if (cmd.tick_load && do_swap) begin
				front_q        <= ~front_q;
				swap_pending_q <= 1'b0;
			end
			if (load_back) begin
				swap_pending_q <= 1'b1;
			end
			if (cmd.write_end && transfer_ok) begin
				write_led_q <= ~write_led_q;
			end
			if (cmd.read_end && transfer_ok) begin
				read_led_q <= ~read_led_q;
			end
			if (cmd.tick_done) begin
				if (level_q == lcdbs_pkg::LEVEL_W'(lcdbs_pkg::LEVELS - 1)) begin
					level_q <= '0;
				end else begin
					level_q <= level_q + 1'b1;
				end
			end
		end
	end

	assign serial_bit  = shift_q[0];
	assign level_index = level_q;
	assign write_led   = write_led_q;
	assign read_led    = read_led_q;

endmodule

// ===== hw/rtl/led_cube_double_buffered_scanner.sv =====
// Channel   Handshake              Payload
// request   start, busy            command, data_byte, transfer_ok
// result    strobe (no back-off)   serial_bit, level_index, latch_after, write_led, read_led
//
// A refresh tick first swaps the halves if a swap is due and loads the shift register,
// then gives one result per bit, paced by the shift register and its bit counter.
// Byte, write-end and read-end requests give no result.
// Reset (arst_n low) restores the test pattern in both frame halves and clears all control.
// Results come one per cycle while busy is high; the receiver cannot stall them.
// Depends on lcdbs_pkg, lcdbs_ctrl and lcdbs_dp.
module led_cube_double_buffered_scanner (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [1:0]                      command,
	input  logic [7:0]                      data_byte,
	input  logic                            transfer_ok,
	output logic                            strobe,
	output logic                            serial_bit,
	output logic [lcdbs_pkg::LEVEL_W-1:0]   level_index,
	output logic                            latch_after,
	output logic                            write_led,
	output logic                            read_led
);

	lcdbs_pkg::ctl_cmd_t cmd;

	lcdbs_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.command     (command),
		.busy        (busy),
		.strobe      (strobe),
		.latch_after (latch_after),
		.cmd         (cmd)
	);

	lcdbs_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.data_byte   (data_byte),
		.transfer_ok (transfer_ok),
		.serial_bit  (serial_bit),
		.level_index (level_index),
		.write_led   (write_led),
		.read_led    (read_led)
	);

endmodule

// ===== dv/led_cube_double_buffered_scanner_test.sv =====
// Self-checking testbench for the double-buffered LED cube scanner.
// Predicts every shifted bit from the request stream; depends on lcdbs_pkg and the top level.
module led_cube_double_buffered_scanner_test;
	import lcdbs_pkg::*;

	// One shifted bit as the receiver should see it
	typedef struct packed {
		logic                 sbit;
		logic [LEVEL_W-1:0]   level;
		logic                 latch;
		logic                 wled;
		logic                 rled;
	} scan_bit_t;

	localparam logic [31:0] TEST_PATTERN [5] = '{
		32'hF000_0001, 32'hE800_0002, 32'hD800_0004, 32'hB800_0008, 32'h7800_0010
	};
	localparam int RANDOM_ITEMS = 270;
	localparam int DRAIN_CYCLES = 2 * (WORD_BITS + 8);

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic [1:0]           command;
	logic [7:0]           data_byte;
	logic                 transfer_ok;
	logic                 strobe;
	logic                 serial_bit;
	logic [LEVEL_W-1:0]   level_index;
	logic                 latch_after;
	logic                 write_led;
	logic                 read_led;

	// Predicted cube state
	logic [WORD_BITS-1:0]   cube_words [FRAME_DEPTH];
	logic                   cube_front;
	logic [7:0]             cube_staging [MESSAGE_BYTES];
	int                     cube_staged;
	int                     cube_level;
	logic                   cube_swap_pending;
	logic                   cube_wled;
	logic                   cube_rled;

	scan_bit_t scan_bits_q [$];
	scan_bit_t want;
	int        fail_count;
	int        request_count;
	int        tick_count;
	int        checked_count;

	led_cube_double_buffered_scanner u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.command     (command),
		.data_byte   (data_byte),
		.transfer_ok (transfer_ok),
		.strobe      (strobe),
		.serial_bit  (serial_bit),
		.level_index (level_index),
		.latch_after (latch_after),
		.write_led   (write_led),
		.read_led    (read_led)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Reset the predicted state to the power-up picture
	function automatic void reset_cube_model();
		for (int h = 0; h < 2; h++) begin
			for (int l = 0; l < LEVELS; l++) begin
				cube_words[h * LEVELS + l] = (l < 5) ? TEST_PATTERN[l] : '0;
			end
		end
		for (int i = 0; i < MESSAGE_BYTES; i++) cube_staging[i] = 8'h00;
		cube_front        = 1'b0;
		cube_staged       = 0;
		cube_level        = 0;
		cube_swap_pending = 1'b0;
		cube_wled         = 1'b0;
		cube_rled         = 1'b0;
	endfunction

	// Apply one accepted request and queue the bits it shifts out
	function automatic void advance_cube_model(cmd_t cmd, logic [7:0] data, logic ok);
		logic [WORD_BITS-1:0] word;
		scan_bit_t            sb;
		int                   back;
		int                   idx;
		case (cmd)
			CMD_TICK: begin
				if (cube_level == 0 && cube_swap_pending) begin
					cube_front        = ~cube_front;
					cube_swap_pending = 1'b0;
				end
				word = cube_words[int'(cube_front) * LEVELS + cube_level];
				for (int i = 0; i < WORD_BITS; i++) begin
					sb.sbit  = word[i];
					sb.level = cube_level[LEVEL_W-1:0];
					sb.latch = (i == WORD_BITS - 1);
					sb.wled  = cube_wled;
					sb.rled  = cube_rled;
					scan_bits_q.push_back(sb);
				end
				cube_level = (cube_level + 1) % LEVELS;
			end
			CMD_BYTE: begin
				if (cube_staged < MESSAGE_BYTES) begin
					cube_staging[cube_staged] = data;
					cube_staged++;
				end
			end
			CMD_WEND: begin
				if (ok) begin
					cube_wled = ~cube_wled;
					if (cube_staging[0] == LOAD_FRAME_OP) begin
						back = cube_front ? 0 : 1;
						for (int w = 0; w < LEVELS; w++) begin
							word = '0;
							for (int b = 0; b < WORD_BYTES; b++) begin
								idx = 1 + w * WORD_BYTES + b;
								if (idx < MESSAGE_BYTES && 8 * b < WORD_BITS) begin
									word = word | (WORD_BITS'(cube_staging[idx]) << (8 * b));
								end
							end
							cube_words[back * LEVELS + w] = word;
						end
						cube_swap_pending = 1'b1;
					end
				end
				for (int i = 0; i < MESSAGE_BYTES; i++) cube_staging[i] = 8'h00;
				cube_staged = 0;
			end
			default: begin
				if (ok) cube_rled = ~cube_rled;
				for (int i = 0; i < MESSAGE_BYTES; i++) cube_staging[i] = 8'h00;
				cube_staged = 0;
			end
		endcase
	endfunction

	// Hold the request idle for a random gap, mostly short, now and then long
	task automatic idle_requester();
		int r;
		int gap;
		r = $urandom_range(0, 99);
		if (r < 50) gap = 0;
		else if (r < 85) gap = $urandom_range(1, 3);
		else if (r < 97) gap = $urandom_range(4, 10);
		else gap = $urandom_range(20, 60);
		if (gap > 0) begin
			@(negedge clk);
			start       = 1'b0;
			command     = 2'($urandom);
			data_byte   = 8'($urandom);
			transfer_ok = 1'($urandom);
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// Present one request and wait until it is taken
	task automatic send_request(cmd_t cmd, logic [7:0] data, logic ok);
		@(negedge clk);
		start       = 1'b1;
		command     = cmd;
		data_byte   = data;
		transfer_ok = ok;
		do @(posedge clk); while (busy);
		advance_cube_model(cmd, data, ok);
		request_count++;
		if (cmd == CMD_TICK) tick_count++;
		idle_requester();
	endtask

	task automatic send_ticks(int n);
		for (int i = 0; i < n; i++) send_request(CMD_TICK, 8'($urandom), 1'($urandom));
	endtask

	// Check each shifted bit against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && strobe) begin
			if (scan_bits_q.size() == 0) begin
				$error("result with no prediction pending");
				fail_count++;
			end else begin
				want = scan_bits_q.pop_front();
				checked_count++;
				if (serial_bit !== want.sbit) begin
					$error("serial_bit: expected %0d, actual %0d", want.sbit, serial_bit);
					fail_count++;
				end
				if (level_index !== want.level) begin
					$error("level_index: expected %0d, actual %0d", want.level, level_index);
					fail_count++;
				end
				if (latch_after !== want.latch) begin
					$error("latch_after: expected %0d, actual %0d", want.latch, latch_after);
					fail_count++;
				end
				if (write_led !== want.wled) begin
					$error("write_led: expected %0d, actual %0d", want.wled, write_led);
					fail_count++;
				end
				if (read_led !== want.rled) begin
					$error("read_led: expected %0d, actual %0d", want.rled, read_led);
					fail_count++;
				end
			end
		end
	end

	// Scan the power-up pattern through every level and wrap around
	task automatic test_reset_pattern();
		send_ticks(6);
	endtask

	// Toggle both LEDs; try an empty, an unknown and a failed write message
	task automatic test_indicators();
		send_request(CMD_REND, 8'h00, 1'b1);
		send_request(CMD_REND, 8'hFF, 1'b0);
		send_request(CMD_WEND, 8'h00, 1'b1);
		send_request(CMD_BYTE, 8'hA5, 1'b0);
		send_request(CMD_WEND, 8'h00, 1'b1);
		send_request(CMD_BYTE, LOAD_FRAME_OP, 1'b1);
		send_request(CMD_WEND, 8'hFF, 1'b0);
		send_ticks(1);
	endtask

	// Load a full frame with extreme bytes, overflow the staging area, then swap
	task automatic test_full_frame();
		send_request(CMD_BYTE, LOAD_FRAME_OP, 1'b0);
		for (int i = 0; i < WORD_BYTES * LEVELS; i++) begin
			send_request(CMD_BYTE, (i % 3 == 0) ? 8'hFF : (i % 3 == 1) ? 8'h00 : 8'h5A,
				1'b1);
		end
		send_request(CMD_BYTE, 8'hFF, 1'b0);
		send_request(CMD_BYTE, 8'hC3, 1'b1);
		send_request(CMD_WEND, 8'h00, 1'b1);
		send_ticks(LEVELS + 1);
	endtask

	// Mostly well-formed messages with random content, plus ticks and noise
	task automatic test_random_traffic();
		int r;
		int nbytes;
		while (request_count < RANDOM_ITEMS) begin
			r = $urandom_range(0, 99);
			if (r < 40) begin
				send_request(CMD_BYTE,
					($urandom_range(0, 99) < 85) ? LOAD_FRAME_OP : 8'($urandom_range(1, 255)),
					1'($urandom));
				r = $urandom_range(0, 99);
				if (r < 60) nbytes = WORD_BYTES * LEVELS;
				else if (r < 80) nbytes = $urandom_range(0, WORD_BYTES * LEVELS - 1);
				else nbytes = $urandom_range(WORD_BYTES * LEVELS + 1, MESSAGE_BYTES + 3);
				for (int i = 0; i < nbytes; i++) begin
					send_request(CMD_BYTE, 8'($urandom), 1'($urandom));
				end
				r = $urandom_range(0, 99);
				if (r < 85) send_request(CMD_WEND, 8'($urandom), 1'b1);
				else if (r < 90) send_request(CMD_WEND, 8'($urandom), 1'b0);
				else send_request(CMD_REND, 8'($urandom), 1'($urandom));
			end else if (r < 75) begin
				send_ticks($urandom_range(1, 6));
			end else if (r < 85) begin
				send_request(CMD_REND, 8'($urandom), 1'($urandom));
			end else begin
				send_request(cmd_t'($urandom_range(0, 3)), 8'($urandom), 1'($urandom));
			end
		end
	endtask

	// Run the tests in turn and report
	initial begin
		arst_n        = 1'b0;
		start         = 1'b0;
		command       = CMD_TICK;
		data_byte     = 8'h00;
		transfer_ok   = 1'b0;
		fail_count    = 0;
		request_count = 0;
		tick_count    = 0;
		checked_count = 0;
		reset_cube_model();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_pattern();
		test_indicators();
		test_full_frame();
		test_random_traffic();

		@(negedge clk);
		start = 1'b0;
		while (scan_bits_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d requests (%0d refresh ticks), checked %0d shifted bits.",
			request_count, tick_count, checked_count);
		if (fail_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	// Stop a hung run
	initial begin
		#3_000_000;
		$display("Timed out with %0d results still pending.", scan_bits_q.size());
		$display("FAIL");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/lcdbs_pkg.sv
hw/rtl/lcdbs_ctrl.sv
hw/rtl/lcdbs_dp.sv
hw/rtl/led_cube_double_buffered_scanner.sv
dv/led_cube_double_buffered_scanner_test.sv
